/* rtl/core/bsf_pkg.sv */
// Shared constants, action codes and word-unit request/response types
// for the bitmap set with find-first. No dependencies.
package bsf_pkg;

	// Bitmap geometry: element values fit the 10-bit element field
	localparam int unsigned MAX_ELEMENTS = 1024;
	localparam int unsigned ELEM_W       = 10;
	localparam int unsigned CAP_W        = 11;
	localparam int unsigned CNT_W        = 11;
	localparam int unsigned WORD_W       = 32;
	localparam int unsigned BIT_W        = $clog2(WORD_W);
	localparam int unsigned NUM_WORDS    = MAX_ELEMENTS / WORD_W;
	localparam int unsigned WADDR_W      = $clog2(NUM_WORDS);

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ELEMENTS);

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_ERASE  = 2'd1,
		ACT_TEST   = 2'd2,
		ACT_FIND   = 2'd3
	} action_t;

	// Request to the word unit for the word currently held in the read register
	typedef struct packed {
		action_t           action;
		logic [BIT_W-1:0]  bit_sel;  // target bit, also lowest bit for a scan
		logic              first_w;  // word holds the scan start
		logic              last_w;   // word holds the last valid element
		logic [BIT_W-1:0]  hi_off;   // highest valid bit in the last word
	} word_req_t;

	typedef struct packed {
		logic              bit_val;
		logic [WORD_W-1:0] new_word;
		logic              changed;
		logic              hit;
		logic [BIT_W-1:0]  hit_pos;
	} word_rsp_t;

endpackage

/* rtl/core/bsf_if.sv */
// Valid/ready channel interfaces for command and result beats.
// Depends on bsf_pkg for field widths.
interface bsf_in_if;
	import bsf_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [ELEM_W-1:0] element;

	modport source(output valid, action, element, input ready);
	modport sink(input valid, action, element, output ready);
endinterface

interface bsf_out_if;
	import bsf_pkg::*;

	logic              valid;
	logic              ready;
	logic              range_error;
	logic              is_member;
	logic              first_found;
	logic [ELEM_W-1:0] first_index;
	logic [CNT_W-1:0]  member_count;
	logic              nonempty;

	modport source(output valid, range_error, is_member, first_found, first_index,
		member_count, nonempty, input ready);
	modport sink(input valid, range_error, is_member, first_found, first_index,
		member_count, nonempty, output ready);
endinterface

/* rtl/core/bsf_bitmap_mem.sv */
// Bitmap word memory: one write port, one registered read port, per-word
// valid flags so the whole set reads as empty right after reset. Uses bsf_pkg.
module bsf_bitmap_mem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [bsf_pkg::WADDR_W-1:0]  rd_addr,
	output logic [bsf_pkg::WORD_W-1:0]   rd_data,
	input  logic                         wr_en,
	input  logic [bsf_pkg::WADDR_W-1:0]  wr_addr,
	input  logic [bsf_pkg::WORD_W-1:0]   wr_data
);
	import bsf_pkg::*;

	logic [WORD_W-1:0]    mem_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] vld_q;
	logic [WORD_W-1:0]    rd_word_q;
	logic                 rd_vld_q;

	// Word storage and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem_q[rd_addr];
		end
	end

	// Track written words; an unwritten word reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

/* rtl/core/bsf_word_unit.sv */
// Shared word unit: bit test, set/clear of one bit, and masked
// find-first-set over one bitmap word. Uses bsf_pkg.
module bsf_word_unit (
	input  logic [bsf_pkg::WORD_W-1:0] word,
	input  bsf_pkg::word_req_t         req,
	output bsf_pkg::word_rsp_t         rsp
);
	import bsf_pkg::*;

	logic [WORD_W-1:0] lo_mask;
	logic [WORD_W-1:0] hi_mask;
	logic [WORD_W-1:0] cand;
	logic [BIT_W-1:0]  pos;

	// Restrict the scan to bits at or above the start and below the limit
	always_comb begin
		lo_mask = req.first_w ? ({WORD_W{1'b1}} << req.bit_sel) : {WORD_W{1'b1}};
		hi_mask = req.last_w ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - req.hi_off))
			: {WORD_W{1'b1}};
		cand = word & lo_mask & hi_mask;
	end

	// Priority encode the lowest candidate bit
	always_comb begin
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				pos = BIT_W'(i);
			end
		end
	end

	// Bit test, scan hit outputs, and bit update for insert and erase
	always_comb begin
		rsp.bit_val  = word[req.bit_sel];
		rsp.new_word = word;
		rsp.changed  = 1'b0;
		rsp.hit      = |cand;
		rsp.hit_pos  = pos;
		case (req.action)
			ACT_INSERT: begin
				rsp.new_word[req.bit_sel] = 1'b1;
				rsp.changed = !word[req.bit_sel];
			end
			ACT_ERASE: begin
				rsp.new_word[req.bit_sel] = 1'b0;
				rsp.changed = word[req.bit_sel];
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/bitmap_set_find_first.sv */
// Bitmap set with find-first: the command beat starts the word read, the EVAL state
// registers the result, and the DONE state loads it into the output registers. Insert,
// erase and test evaluate one word; find-first scans N 32-bit words (1 to 32) at one word
// per cycle through the single memory read port. The next command is taken the cycle after
// the result loads; a result held by the receiver stalls the next command.
// Reset: set empty (per-word valid flags cleared), count zero, capacity 1024.
module bitmap_set_find_first (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bsf_pkg::CAP_W-1:0]  cfg_wdata,
	bsf_in_if.sink                     cmd,
	bsf_out_if.source                  res
);
	import bsf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EVAL = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t              state_q;
	logic [CAP_W-1:0]    cap_q;
	logic [CNT_W-1:0]    count_q;

	action_t             act_q;
	logic [ELEM_W-1:0]   elem_q;
	logic                in_range_q;
	logic [WADDR_W-1:0]  last_w_q;
	logic [BIT_W-1:0]    hi_off_q;
	logic [WADDR_W-1:0]  wp_q;

	logic                res_err_q;
	logic                res_mem_q;
	logic                res_found_q;
	logic [ELEM_W-1:0]   res_idx_q;

	logic                out_valid_q;
	logic                o_err_q;
	logic                o_mem_q;
	logic                o_found_q;
	logic [ELEM_W-1:0]   o_idx_q;
	logic [CNT_W-1:0]    o_cnt_q;
	logic                o_ne_q;

	logic [CAP_W-1:0]    lim;
	logic [CAP_W-1:0]    lim_m1;
	logic                in_range_d;
	logic                accept;
	logic                is_find;
	logic                scan_more;
	logic                eval_end;
	logic                load;

	logic                rd_en;
	logic [WADDR_W-1:0]  rd_addr;
	logic [WORD_W-1:0]   rd_data;
	logic                wr_en;

	word_req_t           req;
	word_rsp_t           rsp;

	// Effective limit and range check of the incoming element
	always_comb begin
		lim        = (cap_q > CAP_W'(MAX_ELEMENTS)) ? CAP_W'(MAX_ELEMENTS) : cap_q;
		lim_m1     = lim - CAP_W'(1);
		in_range_d = {1'b0, cmd.element} < lim;
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;

	// Word unit request for the word in the read register
	always_comb begin
		req.action  = act_q;
		req.bit_sel = elem_q[BIT_W-1:0];
		req.first_w = (wp_q == elem_q[ELEM_W-1:BIT_W]);
		req.last_w  = (wp_q == last_w_q);
		req.hi_off  = hi_off_q;
	end

	// Scan advances while nothing is found and words remain
	always_comb begin
		is_find   = (act_q == ACT_FIND);
		scan_more = (state_q == ST_EVAL) && is_find && in_range_q && !rsp.hit
			&& !req.last_w;
		eval_end  = (state_q == ST_EVAL) && !scan_more;
		wr_en     = (state_q == ST_EVAL) && in_range_q && rsp.changed;
		rd_en     = accept || scan_more;
		rd_addr   = accept ? cmd.element[ELEM_W-1:BIT_W] : WADDR_W'(wp_q + 1'b1);
		load      = (state_q == ST_DONE) && (!out_valid_q || res.ready);
	end

	bsf_bitmap_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wp_q),
		.wr_data (rsp.new_word)
	);

	bsf_word_unit u_word (
		.word (rd_data),
		.req  (req),
		.rsp  (rsp)
	);

	// Sequencer, capacity register, member count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (wr_en) begin
				count_q <= (act_q == ACT_INSERT) ? CNT_W'(count_q + 1'b1)
					: CNT_W'(count_q - 1'b1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (!scan_more) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command, scan pointer and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= action_t'(cmd.action);
			elem_q     <= cmd.element;
			in_range_q <= in_range_d;
			last_w_q   <= lim_m1[ELEM_W-1:BIT_W];
			hi_off_q   <= lim_m1[BIT_W-1:0];
			wp_q       <= cmd.element[ELEM_W-1:BIT_W];
		end else if (scan_more) begin
			wp_q <= WADDR_W'(wp_q + 1'b1);
		end
		if (eval_end) begin
			res_err_q   <= ((act_q == ACT_INSERT) || (act_q == ACT_ERASE)) && !in_range_q;
			res_mem_q   <= (act_q == ACT_TEST) && in_range_q && rsp.bit_val;
			res_found_q <= is_find && in_range_q && rsp.hit;
			res_idx_q   <= (is_find && in_range_q && rsp.hit) ? {wp_q, rsp.hit_pos} : '0;
		end
		if (load) begin
			o_err_q   <= res_err_q;
			o_mem_q   <= res_mem_q;
			o_found_q <= res_found_q;
			o_idx_q   <= res_idx_q;
			o_cnt_q   <= count_q;
			o_ne_q    <= (count_q != '0);
		end
	end

	assign res.valid        = out_valid_q;
	assign res.range_error  = o_err_q;
	assign res.is_member    = o_mem_q;
	assign res.first_found  = o_found_q;
	assign res.first_index  = o_idx_q;
	assign res.member_count = o_cnt_q;
	assign res.nonempty     = o_ne_q;

	// One command in flight at a time
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("command accepted while another is in flight");

	// Member count moves by at most one per cycle
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == CNT_W'($past(count_q) + 1'b1))
		|| (count_q == CNT_W'($past(count_q) - 1'b1)))
		else $error("member count jumped");

	// Only insert and erase write the bitmap
	a_write_kind: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ((act_q == ACT_INSERT) || (act_q == ACT_ERASE)))
		else $error("bitmap written by test or find");

	// Count never exceeds the number of element values
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("member count above bitmap size");

endmodule
